/* rtl/rllt_pkg.sv */
// Shared types and constants of the recursive lease lock table.
`default_nettype none
package rllt_pkg;

   localparam int KEY_W    = 16;
   localparam int NODE_W   = 8;
   localparam int DEPTH_W  = 16;
   localparam int AGE_W    = 22;
   localparam int FUNC_W   = 3;
   localparam int STATUS_W = 3;
   localparam int ACT_W    = 7;
   localparam int TOTAL_W  = 32;
   localparam int REQ_W    = 32;
   localparam int RSP_W    = 160;

   localparam logic [AGE_W-1:0]   AGE_MAX   = '1;
   localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

   // Request operation codes
   typedef enum logic [FUNC_W-1:0] {
      FN_LOCK   = 3'd0,
      FN_UNLOCK = 3'd1,
      FN_RENEW  = 3'd2,
      FN_FORCE  = 3'd3,
      FN_QUERY  = 3'd4,
      FN_TICK   = 3'd5
   } func_type;

   // Answer codes
   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NO_BLOCK  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_CONTENDED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_HELD  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_WRONG_OWN = 3'd4;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;
   localparam logic [STATUS_W-1:0] ST_EXPIRED   = 3'd6;

   // Configuration register indexes
   localparam logic CSR_LEASE = 1'b0;
   localparam logic CSR_HOLD  = 1'b1;

   // One table entry as stored in the entry memory
   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [NODE_W-1:0]  owner;
      logic [DEPTH_W-1:0] depth;
      logic [AGE_W-1:0]   lease;
      logic [AGE_W-1:0]   hold;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Evaluation of one entry by the slot unit
   typedef struct packed {
      logic               key_hit;
      logic               owner_hit;
      logic               expire;
      logic [DEPTH_W-1:0] depth_up;
      logic [DEPTH_W-1:0] depth_down;
      logic               depth_gt1;
      entry_type          aged;
   } slot_eval_type;

endpackage
`default_nettype wire

/* rtl/rllt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rllt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write and read one word a cycle
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire

/* rtl/rllt_slot_unit.sv */
// Shared compare, aging and depth unit applied to one entry at a time.
`default_nettype none
module rllt_slot_unit (
   input  wire rllt_pkg::entry_type            ent,
   input  wire logic [rllt_pkg::KEY_W-1:0]     key,
   input  wire logic [rllt_pkg::NODE_W-1:0]    node,
   input  wire logic [rllt_pkg::AGE_W-1:0]     lease_limit,
   input  wire logic [rllt_pkg::AGE_W-1:0]     hold_limit,
   output rllt_pkg::slot_eval_type             eval
);

   rllt_pkg::entry_type aged;

   // Age both counters, saturating
   always_comb begin
      aged = ent;
      if (ent.lease != rllt_pkg::AGE_MAX) begin
         aged.lease = ent.lease + 1'b1;
      end
      if (ent.hold != rllt_pkg::AGE_MAX) begin
         aged.hold = ent.hold + 1'b1;
      end
   end

   // Compare key and owner, judge expiry, step depth
   always_comb begin
      eval.key_hit    = (ent.key == key);
      eval.owner_hit  = (ent.owner == node);
      eval.expire     = (aged.lease > lease_limit) || (aged.hold > hold_limit);
      eval.depth_up   = (ent.depth == rllt_pkg::DEPTH_MAX) ? ent.depth : ent.depth + 1'b1;
      eval.depth_down = ent.depth - 1'b1;
      eval.depth_gt1  = (ent.depth > rllt_pkg::DEPTH_W'(1));
      eval.aged       = aged;
   end

endmodule
`default_nettype wire

/* rtl/recursive_lease_lock_table.sv */
// Top level of the recursive lease lock table: sequencer, counters and ports.
// Usage:
//  req_* carries one request beat: func, block_key, node, block_present.
//  rsp_* returns result beats; rsp_tlast marks the final beat of a request.
//  csr_* writes lease_limit (index 0) or hold_limit (index 1).
// Sequence:
//  Lock requests walk the entry memory one slot at a time, reading each held
//  slot and passing over each free one, stopping at the first key match, then
//  apply in S_APPLY; the result beat is valid on the next cycle.
//  A tick ages every held slot and then reads back each freed slot, passing
//  over the others, to send its beat; with none freed it sends one OK beat.
//  req_tready is high only while idle, from the cycle after the last beat leaves.
// Reset:
//  Synchronous reset empties the table, clears totals, restores the limits.
// Stall:
//  A result beat holds in the output register until rsp_tready; the table
//  waits and takes no new request meanwhile.
`default_nettype none
module recursive_lease_lock_table #(
   parameter int ENTRIES = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // func[2:0], block_key[18:3], node[26:19], block_present[27], zero[31:28]
   input  wire logic [rllt_pkg::REQ_W-1:0]    req_tdata,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // status[2:0], held[3], holder[11:4], depth[27:12], held_by_requester[28],
   // expired_key[44:29], expired_owner[52:45], active_count[59:53],
   // contentions[91:60], expiries[123:92], acquisitions[155:124], zero[159:156]
   output logic [rllt_pkg::RSP_W-1:0]         rsp_tdata,
   output logic                               rsp_tlast,
   input  wire logic                          csr_we,
   input  wire logic                          csr_addr,
   input  wire logic [rllt_pkg::AGE_W-1:0]    csr_wdata
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);

   typedef enum logic [8:0] {
      S_IDLE    = 9'b000000001,
      S_LK_RD   = 9'b000000010,
      S_LK_EX   = 9'b000000100,
      S_APPLY   = 9'b000001000,
      S_TK_RD   = 9'b000010000,
      S_TK_EX   = 9'b000100000,
      S_TK_SEEK = 9'b001000000,
      S_TK_LOAD = 9'b010000000,
      S_OUT     = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   logic [rllt_pkg::AGE_W-1:0] lease_limit_ff, lease_limit_in;
   logic [rllt_pkg::AGE_W-1:0] hold_limit_ff, hold_limit_in;

   rllt_pkg::func_type            func_ff, func_in;
   logic [rllt_pkg::KEY_W-1:0]    key_ff, key_in;
   logic [rllt_pkg::NODE_W-1:0]   node_ff, node_in;
   logic                          present_ff, present_in;

   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [IDX_W-1:0]   slot_ff, slot_in;
   logic               found_ff, found_in;
   logic [IDX_W-1:0]   free_ff, free_in;
   logic               free_found_ff, free_found_in;
   rllt_pkg::entry_type ent_ff, ent_in;
   logic [CNT_W-1:0]   exp_cnt_ff, exp_cnt_in;

   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [ENTRIES-1:0] flag_ff, flag_in;

   logic [rllt_pkg::ACT_W-1:0]   act_ff, act_in;
   logic [rllt_pkg::TOTAL_W-1:0] cont_ff, cont_in;
   logic [rllt_pkg::TOTAL_W-1:0] expt_ff, expt_in;
   logic [rllt_pkg::TOTAL_W-1:0] acq_ff, acq_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_last_ff, rsp_last_in;
   logic [rllt_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic                            rsp_held_ff, rsp_held_in;
   logic [rllt_pkg::NODE_W-1:0]     rsp_holder_ff, rsp_holder_in;
   logic [rllt_pkg::DEPTH_W-1:0]    rsp_depth_ff, rsp_depth_in;
   logic                            rsp_hbr_ff, rsp_hbr_in;
   logic [rllt_pkg::KEY_W-1:0]      rsp_ekey_ff, rsp_ekey_in;
   logic [rllt_pkg::NODE_W-1:0]     rsp_eown_ff, rsp_eown_in;

   logic                     ram_we;
   logic [IDX_W-1:0]         ram_waddr;
   rllt_pkg::entry_type      ram_wdata;
   logic [IDX_W-1:0]         ram_raddr;
   logic [rllt_pkg::ENTRY_W-1:0] ram_rdata;

   rllt_pkg::entry_type     unit_ent;
   rllt_pkg::slot_eval_type ev;

   logic [IDX_W-1:0] idx_slot;
   logic             scan_done;

   assign idx_slot  = idx_ff[IDX_W-1:0];
   assign scan_done = (idx_ff == CNT_W'(ENTRIES));
   assign unit_ent  = (state_ff == S_APPLY) ? ent_ff : rllt_pkg::entry_type'(ram_rdata);

   rllt_ram #(
      .WIDTH (rllt_pkg::ENTRY_W),
      .DEPTH (ENTRIES)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   rllt_slot_unit u_unit (
      .ent         (unit_ent),
      .key         (key_ff),
      .node        (node_ff),
      .lease_limit (lease_limit_ff),
      .hold_limit  (hold_limit_ff),
      .eval        (ev)
   );

   // Drive the ports
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {4'b0, acq_ff, expt_ff, cont_ff, act_ff, rsp_eown_ff, rsp_ekey_ff,
                        rsp_hbr_ff, rsp_depth_ff, rsp_holder_ff, rsp_held_ff, rsp_status_ff};

   // Sequence lookups, ticks and result beats
   always_comb begin
      state_in       = state_ff;
      lease_limit_in = lease_limit_ff;
      hold_limit_in  = hold_limit_ff;
      func_in        = func_ff;
      key_in         = key_ff;
      node_in        = node_ff;
      present_in     = present_ff;
      idx_in         = idx_ff;
      slot_in        = slot_ff;
      found_in       = found_ff;
      free_in        = free_ff;
      free_found_in  = free_found_ff;
      ent_in         = ent_ff;
      exp_cnt_in     = exp_cnt_ff;
      valid_in       = valid_ff;
      flag_in        = flag_ff;
      act_in         = act_ff;
      cont_in        = cont_ff;
      expt_in        = expt_ff;
      acq_in         = acq_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_held_in    = rsp_held_ff;
      rsp_holder_in  = rsp_holder_ff;
      rsp_depth_in   = rsp_depth_ff;
      rsp_hbr_in     = rsp_hbr_ff;
      rsp_ekey_in    = rsp_ekey_ff;
      rsp_eown_in    = rsp_eown_ff;
      ram_we         = 1'b0;
      ram_waddr      = slot_ff;
      ram_wdata      = ent_ff;
      ram_raddr      = idx_slot;

      // Take limit writes
      if (csr_we) begin
         if (csr_addr == rllt_pkg::CSR_LEASE) begin
            lease_limit_in = csr_wdata;
         end else begin
            hold_limit_in = csr_wdata;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               func_in       = rllt_pkg::func_type'(req_tdata[2:0]);
               key_in        = req_tdata[18:3];
               node_in       = req_tdata[26:19];
               present_in    = req_tdata[27];
               idx_in        = '0;
               found_in      = 1'b0;
               free_found_in = 1'b0;
               exp_cnt_in    = '0;
               flag_in       = '0;
               if (rllt_pkg::func_type'(req_tdata[2:0]) == rllt_pkg::FN_TICK) begin
                  state_in = S_TK_RD;
               end else begin
                  state_in = S_LK_RD;
               end
            end
         end
         S_LK_RD: begin
            // Read held slots, note the lowest free one
            if (scan_done) begin
               state_in = S_APPLY;
            end else if (valid_ff[idx_slot]) begin
               state_in = S_LK_EX;
            end else begin
               if (!free_found_ff) begin
                  free_found_in = 1'b1;
                  free_in       = idx_slot;
               end
               idx_in = idx_ff + 1'b1;
            end
         end
         S_LK_EX: begin
            if (ev.key_hit) begin
               found_in = 1'b1;
               slot_in  = idx_slot;
               ent_in   = rllt_pkg::entry_type'(ram_rdata);
               state_in = S_APPLY;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_LK_RD;
            end
         end
         S_APPLY: begin
            rsp_status_in = rllt_pkg::ST_OK;
            rsp_held_in   = found_ff;
            rsp_holder_in = found_ff ? ent_ff.owner : '0;
            rsp_depth_in  = found_ff ? ent_ff.depth : '0;
            rsp_hbr_in    = found_ff && ev.owner_hit;
            rsp_ekey_in   = '0;
            rsp_eown_in   = '0;
            rsp_last_in   = 1'b1;
            rsp_valid_in  = 1'b1;
            state_in      = S_OUT;
            case (func_ff)
               rllt_pkg::FN_LOCK: begin
                  if (!present_ff) begin
                     rsp_status_in = rllt_pkg::ST_NO_BLOCK;
                  end else if (found_ff) begin
                     if (ev.owner_hit) begin
                        ram_we          = 1'b1;
                        ram_wdata.depth = ev.depth_up;
                        ram_wdata.lease = '0;
                        rsp_depth_in    = ev.depth_up;
                     end else begin
                        rsp_status_in = rllt_pkg::ST_CONTENDED;
                        cont_in       = cont_ff + 1'b1;
                     end
                  end else if (!free_found_ff) begin
                     rsp_status_in = rllt_pkg::ST_FULL;
                  end else begin
                     ram_we          = 1'b1;
                     ram_waddr       = free_ff;
                     ram_wdata.key   = key_ff;
                     ram_wdata.owner = node_ff;
                     ram_wdata.depth = rllt_pkg::DEPTH_W'(1);
                     ram_wdata.lease = '0;
                     ram_wdata.hold  = '0;
                     valid_in[free_ff] = 1'b1;
                     act_in        = act_ff + 1'b1;
                     acq_in        = acq_ff + 1'b1;
                     rsp_held_in   = 1'b1;
                     rsp_holder_in = node_ff;
                     rsp_depth_in  = rllt_pkg::DEPTH_W'(1);
                     rsp_hbr_in    = 1'b1;
                  end
               end
               rllt_pkg::FN_UNLOCK: begin
                  if (!found_ff) begin
                     rsp_status_in = rllt_pkg::ST_NOT_HELD;
                  end else if (!ev.owner_hit) begin
                     rsp_status_in = rllt_pkg::ST_WRONG_OWN;
                  end else if (ev.depth_gt1) begin
                     ram_we          = 1'b1;
                     ram_wdata.depth = ev.depth_down;
                     rsp_depth_in    = ev.depth_down;
                  end else begin
                     valid_in[slot_ff] = 1'b0;
                     act_in        = act_ff - 1'b1;
                     rsp_held_in   = 1'b0;
                     rsp_holder_in = '0;
                     rsp_depth_in  = '0;
                     rsp_hbr_in    = 1'b0;
                  end
               end
               rllt_pkg::FN_RENEW: begin
                  if (!found_ff) begin
                     rsp_status_in = rllt_pkg::ST_NOT_HELD;
                  end else if (!ev.owner_hit) begin
                     rsp_status_in = rllt_pkg::ST_WRONG_OWN;
                  end else begin
                     ram_we          = 1'b1;
                     ram_wdata.lease = '0;
                  end
               end
               rllt_pkg::FN_FORCE: begin
                  if (!found_ff) begin
                     rsp_status_in = rllt_pkg::ST_NOT_HELD;
                  end else begin
                     valid_in[slot_ff] = 1'b0;
                     act_in        = act_ff - 1'b1;
                     expt_in       = expt_ff + 1'b1;
                     rsp_held_in   = 1'b0;
                     rsp_holder_in = '0;
                     rsp_depth_in  = '0;
                     rsp_hbr_in    = 1'b0;
                  end
               end
               default: begin
               end
            endcase
         end
         S_TK_RD: begin
            // Age pass over held slots
            if (scan_done) begin
               if (exp_cnt_ff == '0) begin
                  rsp_status_in = rllt_pkg::ST_OK;
                  rsp_held_in   = 1'b0;
                  rsp_holder_in = '0;
                  rsp_depth_in  = '0;
                  rsp_hbr_in    = 1'b0;
                  rsp_ekey_in   = '0;
                  rsp_eown_in   = '0;
                  rsp_last_in   = 1'b1;
                  rsp_valid_in  = 1'b1;
                  state_in      = S_OUT;
               end else begin
                  idx_in   = '0;
                  state_in = S_TK_SEEK;
               end
            end else if (valid_ff[idx_slot]) begin
               state_in = S_TK_EX;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_TK_EX: begin
            ram_we    = 1'b1;
            ram_waddr = idx_slot;
            ram_wdata = ev.aged;
            if (ev.expire) begin
               valid_in[idx_slot] = 1'b0;
               flag_in[idx_slot]  = 1'b1;
               exp_cnt_in = exp_cnt_ff + 1'b1;
               expt_in    = expt_ff + 1'b1;
               act_in     = act_ff - 1'b1;
            end
            idx_in   = idx_ff + 1'b1;
            state_in = S_TK_RD;
         end
         S_TK_SEEK: begin
            // Find the next freed slot and read it back
            if (flag_ff[idx_slot]) begin
               state_in = S_TK_LOAD;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_TK_LOAD: begin
            rsp_status_in = rllt_pkg::ST_EXPIRED;
            rsp_held_in   = 1'b0;
            rsp_holder_in = '0;
            rsp_depth_in  = '0;
            rsp_hbr_in    = 1'b0;
            rsp_ekey_in   = ev.aged.key;
            rsp_eown_in   = ev.aged.owner;
            rsp_last_in   = (exp_cnt_ff == CNT_W'(1));
            rsp_valid_in  = 1'b1;
            state_in      = S_OUT;
         end
         S_OUT: begin
            // Hold the beat until taken
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  exp_cnt_in = exp_cnt_ff - 1'b1;
                  idx_in     = idx_ff + 1'b1;
                  state_in   = S_TK_SEEK;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         lease_limit_ff <= rllt_pkg::AGE_W'(5000);
         hold_limit_ff  <= rllt_pkg::AGE_W'(30000);
         valid_ff       <= '0;
         act_ff         <= '0;
         cont_ff        <= '0;
         expt_ff        <= '0;
         acq_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         lease_limit_ff <= lease_limit_in;
         hold_limit_ff  <= hold_limit_in;
         valid_ff       <= valid_in;
         act_ff         <= act_in;
         cont_ff        <= cont_in;
         expt_ff        <= expt_in;
         acq_ff         <= acq_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Working and payload registers
   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      key_ff        <= key_in;
      node_ff       <= node_in;
      present_ff    <= present_in;
      idx_ff        <= idx_in;
      slot_ff       <= slot_in;
      found_ff      <= found_in;
      free_ff       <= free_in;
      free_found_ff <= free_found_in;
      ent_ff        <= ent_in;
      exp_cnt_ff    <= exp_cnt_in;
      flag_ff       <= flag_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_held_ff   <= rsp_held_in;
      rsp_holder_ff <= rsp_holder_in;
      rsp_depth_ff  <= rsp_depth_in;
      rsp_hbr_ff    <= rsp_hbr_in;
      rsp_ekey_ff   <= rsp_ekey_in;
      rsp_eown_ff   <= rsp_eown_in;
   end

endmodule
`default_nettype wire

/* dv/recursive_lease_lock_table_tb.sv */
// Self-checking testbench of the recursive lease lock table.
`default_nettype none
module recursive_lease_lock_table_tb;

   localparam int NSLOT = 16;
   localparam int LIMIT_CYCLES = 400000;

   // One result beat as predicted
   typedef struct {
      logic [rllt_pkg::STATUS_W-1:0] status;
      logic                          held;
      logic [rllt_pkg::NODE_W-1:0]   holder;
      logic [rllt_pkg::DEPTH_W-1:0]  depth;
      logic                          mine;
      logic [rllt_pkg::KEY_W-1:0]    exp_key;
      logic [rllt_pkg::NODE_W-1:0]   exp_owner;
      logic                          last;
      logic [rllt_pkg::ACT_W-1:0]    active;
      logic [rllt_pkg::TOTAL_W-1:0]  contentions;
      logic [rllt_pkg::TOTAL_W-1:0]  expiries;
      logic [rllt_pkg::TOTAL_W-1:0]  acquisitions;
   } lock_answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [rllt_pkg::REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [rllt_pkg::RSP_W-1:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_we = 1'b0;
   logic csr_addr = 1'b0;
   logic [rllt_pkg::AGE_W-1:0] csr_wdata = '0;

   // Shadow of the lock table
   logic                         sh_valid [NSLOT];
   logic [rllt_pkg::KEY_W-1:0]   sh_key   [NSLOT];
   logic [rllt_pkg::NODE_W-1:0]  sh_owner [NSLOT];
   logic [rllt_pkg::DEPTH_W-1:0] sh_depth [NSLOT];
   logic [rllt_pkg::AGE_W-1:0]   sh_lease [NSLOT];
   logic [rllt_pkg::AGE_W-1:0]   sh_hold  [NSLOT];
   logic [rllt_pkg::AGE_W-1:0]   lease_lim, hold_lim;
   logic [rllt_pkg::TOTAL_W-1:0] n_contend, n_expire, n_acquire;

   lock_answer_type pending_answers[$];
   int errors = 0;
   int cycles = 0;
   bit calm = 1'b0;

   recursive_lease_lock_table #(.ENTRIES(NSLOT)) DUT (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // Abort on a hang
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
      errors++;
   endtask

   // Append one beat to the expected list
   task automatic enqueue_answer(input lock_answer_type a);
      pending_answers = {pending_answers, a};
   endtask

   function automatic int find_lock(input logic [rllt_pkg::KEY_W-1:0] key);
      for (int i = 0; i < NSLOT; i++)
         if (sh_valid[i] && sh_key[i] == key) return i;
      return -1;
   endfunction

   function automatic logic [rllt_pkg::ACT_W-1:0] held_count();
      logic [rllt_pkg::ACT_W-1:0] n;
      n = '0;
      for (int i = 0; i < NSLOT; i++) n += rllt_pkg::ACT_W'(sh_valid[i]);
      return n;
   endfunction

   // Apply one request to the shadow table and queue its answers
   task automatic predict_locks(input logic [2:0] fn, input logic [rllt_pkg::KEY_W-1:0] key,
                                input logic [rllt_pkg::NODE_W-1:0] node, input logic present);
      lock_answer_type a, freed[$];
      logic [rllt_pkg::STATUS_W-1:0] st;
      int s, f;
      st = rllt_pkg::ST_OK;
      if (fn == rllt_pkg::FN_TICK) begin
         for (int i = 0; i < NSLOT; i++) if (sh_valid[i]) begin
            if (sh_lease[i] != rllt_pkg::AGE_MAX) sh_lease[i]++;
            if (sh_hold[i] != rllt_pkg::AGE_MAX) sh_hold[i]++;
         end
         for (int i = 0; i < NSLOT; i++)
            if (sh_valid[i] && (sh_lease[i] > lease_lim || sh_hold[i] > hold_lim)) begin
               sh_valid[i] = 1'b0;
               n_expire++;
               a = '{default: '0};
               a.status = rllt_pkg::ST_EXPIRED;
               a.exp_key = sh_key[i];
               a.exp_owner = sh_owner[i];
               freed = {freed, a};
            end
         if (freed.size() == 0) begin
            a = '{default: '0};
            freed = {freed, a};
         end
         freed[freed.size()-1].last = 1'b1;
         foreach (freed[i]) begin
            freed[i].active = held_count();
            freed[i].contentions = n_contend;
            freed[i].expiries = n_expire;
            freed[i].acquisitions = n_acquire;
            enqueue_answer(freed[i]);
         end
         return;
      end
      s = find_lock(key);
      case (fn)
         rllt_pkg::FN_LOCK: begin
            if (!present) st = rllt_pkg::ST_NO_BLOCK;
            else if (s >= 0) begin
               if (sh_owner[s] == node) begin
                  if (sh_depth[s] != rllt_pkg::DEPTH_MAX) sh_depth[s]++;
                  sh_lease[s] = '0;
               end else begin
                  n_contend++;
                  st = rllt_pkg::ST_CONTENDED;
               end
            end else begin
               f = -1;
               for (int i = NSLOT - 1; i >= 0; i--) if (!sh_valid[i]) f = i;
               if (f < 0) st = rllt_pkg::ST_FULL;
               else begin
                  sh_valid[f] = 1'b1;
                  sh_key[f] = key;
                  sh_owner[f] = node;
                  sh_depth[f] = 16'd1;
                  sh_lease[f] = '0;
                  sh_hold[f] = '0;
                  n_acquire++;
               end
            end
         end
         rllt_pkg::FN_UNLOCK: begin
            if (s < 0) st = rllt_pkg::ST_NOT_HELD;
            else if (sh_owner[s] != node) st = rllt_pkg::ST_WRONG_OWN;
            else if (sh_depth[s] > 16'd1) sh_depth[s]--;
            else sh_valid[s] = 1'b0;
         end
         rllt_pkg::FN_RENEW: begin
            if (s < 0) st = rllt_pkg::ST_NOT_HELD;
            else if (sh_owner[s] != node) st = rllt_pkg::ST_WRONG_OWN;
            else sh_lease[s] = '0;
         end
         rllt_pkg::FN_FORCE: begin
            if (s < 0) st = rllt_pkg::ST_NOT_HELD;
            else begin
               sh_valid[s] = 1'b0;
               n_expire++;
            end
         end
         default: ;
      endcase
      a = '{default: '0};
      a.status = st;
      s = find_lock(key);
      if (s >= 0) begin
         a.held = 1'b1;
         a.holder = sh_owner[s];
         a.depth = sh_depth[s];
         a.mine = (sh_owner[s] == node);
      end
      a.last = 1'b1;
      a.active = held_count();
      a.contentions = n_contend;
      a.expiries = n_expire;
      a.acquisitions = n_acquire;
      enqueue_answer(a);
   endtask

   // Send one request beat, idling at random before it
   task automatic send_request(input logic [2:0] fn, input logic [rllt_pkg::KEY_W-1:0] key,
                               input logic [rllt_pkg::NODE_W-1:0] node, input logic present);
      while (!calm && $urandom_range(99) < 35) @(posedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= {4'b0, present, node, key, fn};
      do @(posedge clock); while (!req_tready);
      predict_locks(fn, key, node, present);
      req_tvalid <= 1'b0;
      // Step past the accepting edge; the table is busy here anyway
      @(posedge clock);
   endtask

   // Drain the expected answers, then let the block settle
   task automatic wait_drained();
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (2 * NSLOT * 3 + 10) @(posedge clock);
   endtask

   task automatic write_limit(input logic idx, input logic [rllt_pkg::AGE_W-1:0] val);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == rllt_pkg::CSR_LEASE) lease_lim = val; else hold_lim = val;
      @(posedge clock);
   endtask

   // Check result beats, stalling the receiver at random
   always @(posedge clock) begin
      lock_answer_type e;
      if (rsp_tvalid && rsp_tready) begin
         if (pending_answers.size() == 0) report("unexpected beat", rsp_tdata[31:0], '0);
         else begin
            e = pending_answers.pop_front();
            if (rsp_tdata[2:0] != e.status)
               report("status", 32'(rsp_tdata[2:0]), 32'(e.status));
            if (rsp_tdata[3] != e.held) report("held", 32'(rsp_tdata[3]), 32'(e.held));
            if (rsp_tdata[11:4] != e.holder)
               report("holder", 32'(rsp_tdata[11:4]), 32'(e.holder));
            if (rsp_tdata[27:12] != e.depth)
               report("depth", 32'(rsp_tdata[27:12]), 32'(e.depth));
            if (rsp_tdata[28] != e.mine)
               report("held_by_requester", 32'(rsp_tdata[28]), 32'(e.mine));
            if (rsp_tdata[44:29] != e.exp_key)
               report("expired_key", 32'(rsp_tdata[44:29]), 32'(e.exp_key));
            if (rsp_tdata[52:45] != e.exp_owner)
               report("expired_owner", 32'(rsp_tdata[52:45]), 32'(e.exp_owner));
            if (rsp_tlast != e.last) report("last", 32'(rsp_tlast), 32'(e.last));
            if (rsp_tdata[59:53] != e.active)
               report("active_count", 32'(rsp_tdata[59:53]), 32'(e.active));
            if (rsp_tdata[91:60] != e.contentions)
               report("contentions", rsp_tdata[91:60], e.contentions);
            if (rsp_tdata[123:92] != e.expiries)
               report("expiries", rsp_tdata[123:92], e.expiries);
            if (rsp_tdata[155:124] != e.acquisitions)
               report("acquisitions", rsp_tdata[155:124], e.acquisitions);
         end
      end
      rsp_tready <= calm || ($urandom_range(99) >= 35);
   end

   // Extremes of fields and every operation with default limits
   task automatic test_directed();
      send_request(rllt_pkg::FN_QUERY, 16'h0000, 8'h00, 1'b0);
      send_request(rllt_pkg::FN_TICK, 16'hFFFF, 8'hFF, 1'b1);
      send_request(rllt_pkg::FN_LOCK, 16'hFFFF, 8'hFF, 1'b0);
      send_request(rllt_pkg::FN_LOCK, 16'hFFFF, 8'hFF, 1'b1);
      send_request(rllt_pkg::FN_LOCK, 16'hFFFF, 8'hFF, 1'b1);
      send_request(rllt_pkg::FN_LOCK, 16'hFFFF, 8'h00, 1'b1);
      send_request(rllt_pkg::FN_UNLOCK, 16'hFFFF, 8'h00, 1'b1);
      send_request(rllt_pkg::FN_RENEW, 16'hFFFF, 8'h00, 1'b0);
      send_request(rllt_pkg::FN_RENEW, 16'hFFFF, 8'hFF, 1'b0);
      send_request(rllt_pkg::FN_UNLOCK, 16'hFFFF, 8'hFF, 1'b0);
      send_request(rllt_pkg::FN_UNLOCK, 16'hFFFF, 8'hFF, 1'b0);
      send_request(rllt_pkg::FN_UNLOCK, 16'hFFFF, 8'hFF, 1'b0);
      send_request(rllt_pkg::FN_RENEW, 16'h0000, 8'h00, 1'b1);
      send_request(rllt_pkg::FN_FORCE, 16'h0000, 8'h00, 1'b1);
      send_request(rllt_pkg::FN_LOCK, 16'h0000, 8'h00, 1'b1);
      send_request(rllt_pkg::FN_FORCE, 16'h0000, 8'hA5, 1'b0);
      send_request(3'd6, 16'h5A5A, 8'h5A, 1'b1);
      send_request(3'd7, 16'hA5A5, 8'hA5, 1'b0);
      wait_drained();
   endtask

   // Fill the table past its size, then drain it by force
   task automatic test_full_table();
      for (int i = 0; i <= NSLOT; i++)
         send_request(rllt_pkg::FN_LOCK, 16'(16'h100 + i), 8'(i), 1'b1);
      for (int i = 0; i <= NSLOT; i++)
         send_request(rllt_pkg::FN_FORCE, 16'(16'h100 + i), 8'h00, 1'b1);
      wait_drained();
   endtask

   // Zero and tiny limits expire locks on early ticks
   task automatic test_expiry();
      write_limit(rllt_pkg::CSR_LEASE, '0);
      write_limit(rllt_pkg::CSR_HOLD, 22'h3FFFFF);
      for (int i = 0; i < 5; i++)
         send_request(rllt_pkg::FN_LOCK, 16'(16'h200 + i), 8'(8'h10 + i), 1'b1);
      send_request(rllt_pkg::FN_TICK, '0, '0, 1'b0);
      wait_drained();
      write_limit(rllt_pkg::CSR_LEASE, 22'h3FFFFF);
      write_limit(rllt_pkg::CSR_HOLD, 22'd2);
      for (int i = 0; i < 4; i++)
         send_request(rllt_pkg::FN_LOCK, 16'(16'h300 + i), 8'h20, 1'b1);
      send_request(rllt_pkg::FN_TICK, '0, '0, 1'b0);
      send_request(rllt_pkg::FN_RENEW, 16'h300, 8'h20, 1'b1);
      send_request(rllt_pkg::FN_TICK, '0, '0, 1'b0);
      send_request(rllt_pkg::FN_TICK, '0, '0, 1'b0);
      wait_drained();
   endtask

   // Random traffic over a small key and node set so that locks collide
   task automatic test_random(input int count, input logic [rllt_pkg::AGE_W-1:0] lease,
                              input logic [rllt_pkg::AGE_W-1:0] hold);
      logic [2:0] fn;
      logic [rllt_pkg::KEY_W-1:0] key;
      logic [rllt_pkg::NODE_W-1:0] node;
      write_limit(rllt_pkg::CSR_LEASE, lease);
      write_limit(rllt_pkg::CSR_HOLD, hold);
      for (int i = 0; i < count; i++) begin
         fn = ($urandom_range(99) < 30) ? rllt_pkg::FN_LOCK : 3'($urandom_range(7));
         key = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(11));
         node = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(3));
         send_request(fn, key, node, $urandom_range(9) != 0);
         if (i == count / 2) begin
            // hold off until every answer is back
            while (pending_answers.size() != 0) @(posedge clock);
         end
      end
      wait_drained();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < NSLOT; i++) sh_valid[i] = 1'b0;
      lease_lim = 22'd5000;
      hold_lim = 22'd30000;
      n_contend = '0;
      n_expire = '0;
      n_acquire = '0;
      test_directed();
      test_full_table();
      test_expiry();
      test_random(80, 22'd3, 22'd6);
      calm = 1'b1;
      test_random(50, 22'd1, 22'h3FFFFF);
      calm = 1'b0;
      test_random(80, 22'h3FFFFF, 22'd4);
      test_random(50, 22'd2, 22'd3);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
